// File: src/assert_macros.svh
// Assertion macros shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/tte_pkg.sv
package tte_pkg;

    // Command codes
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Special tokens
    localparam logic [4:0] TOK_DOWN = 5'd30;
    localparam logic [4:0] TOK_UP   = 5'd31;

    // Most tokens one item can cause
    localparam int MAX_TOK = 5;

    // Shift levels
    localparam logic [1:0] LVL_WORD  = 2'd0;
    localparam logic [1:0] LVL_SPEC  = 2'd1;
    localparam logic [1:0] LVL_SPEC2 = 2'd2;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_UPPER,
        CLS_LOWER,
        CLS_PUNCT,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [4:0] code;
    } t_char_info;

    // One queued item: its token list, length and common status
    typedef struct packed {
        logic [MAX_TOK-1:0][4:0] tok;
        logic [2:0]              n;
        logic [1:0]              status;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_qwr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Classify one text byte and give its code within its class
    function automatic t_char_info tte_classify(input logic [7:0] c);
        t_char_info r;
        r.cls  = CLS_BAD;
        r.code = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.cls  = CLS_DIGIT;
            r.code = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.cls  = CLS_UPPER;
            r.code = 5'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.cls  = CLS_LOWER;
            r.code = 5'(c - 8'h61);
        end else begin
            case (c)
                8'h20: begin r.cls = CLS_UPPER; r.code = 5'd26; end
                8'h2E: begin r.cls = CLS_UPPER; r.code = 5'd27; end
                8'h40: begin r.cls = CLS_LOWER; r.code = 5'd26; end
                8'h2D: begin r.cls = CLS_LOWER; r.code = 5'd27; end
                8'h21: begin r.cls = CLS_PUNCT; r.code = 5'd0;  end
                8'h22: begin r.cls = CLS_PUNCT; r.code = 5'd1;  end
                8'h23: begin r.cls = CLS_PUNCT; r.code = 5'd2;  end
                8'h24: begin r.cls = CLS_PUNCT; r.code = 5'd3;  end
                8'h25: begin r.cls = CLS_PUNCT; r.code = 5'd4;  end
                8'h26: begin r.cls = CLS_PUNCT; r.code = 5'd5;  end
                8'h27: begin r.cls = CLS_PUNCT; r.code = 5'd6;  end
                8'h28: begin r.cls = CLS_PUNCT; r.code = 5'd7;  end
                8'h29: begin r.cls = CLS_PUNCT; r.code = 5'd8;  end
                8'h2A: begin r.cls = CLS_PUNCT; r.code = 5'd9;  end
                8'h2B: begin r.cls = CLS_PUNCT; r.code = 5'd10; end
                8'h2C: begin r.cls = CLS_PUNCT; r.code = 5'd11; end
                8'h2F: begin r.cls = CLS_PUNCT; r.code = 5'd12; end
                8'h3A: begin r.cls = CLS_PUNCT; r.code = 5'd13; end
                8'h3B: begin r.cls = CLS_PUNCT; r.code = 5'd14; end
                8'h3C: begin r.cls = CLS_PUNCT; r.code = 5'd15; end
                8'h3D: begin r.cls = CLS_PUNCT; r.code = 5'd16; end
                8'h3E: begin r.cls = CLS_PUNCT; r.code = 5'd17; end
                8'h3F: begin r.cls = CLS_PUNCT; r.code = 5'd18; end
                8'h5B: begin r.cls = CLS_PUNCT; r.code = 5'd19; end
                8'h5C: begin r.cls = CLS_PUNCT; r.code = 5'd20; end
                8'h5D: begin r.cls = CLS_PUNCT; r.code = 5'd21; end
                8'h5E: begin r.cls = CLS_PUNCT; r.code = 5'd22; end
                8'h5F: begin r.cls = CLS_PUNCT; r.code = 5'd23; end
                8'h60: begin r.cls = CLS_PUNCT; r.code = 5'd24; end
                8'h7B: begin r.cls = CLS_PUNCT; r.code = 5'd25; end
                8'h7C: begin r.cls = CLS_PUNCT; r.code = 5'd26; end
                8'h7D: begin r.cls = CLS_PUNCT; r.code = 5'd27; end
                default: begin r.cls = CLS_BAD; r.code = 5'd0; end
            endcase
        end
        return r;
    endfunction

endpackage

// File: src/tte_in_if.sv
interface tte_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] character;

    modport source (output valid, output cmd, output character, input ready);
    modport sink   (input valid, input cmd, input character, output ready);
endinterface

// File: src/tte_out_if.sv
interface tte_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] token;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output token, output status, output last, input ready);
    modport sink   (input valid, input token, input status, input last, output ready);
endinterface

// File: src/text_to_five_bit_token_encoder.sv
// Path: an item is written into the entry queue, then its first token is loaded
// into the output register, where a stalled sink can hold it.
// Throughput: one input item per cycle while the entry queue has room;
// output is one token per cycle while the sink is ready, set by the single
// output register stepping through each entry's tokens (1 to 5).
// Reset (synchronous, active low): queue empty, shift level word, count 0,
// capacity 65535.
`include "assert_macros.svh"

module text_to_five_bit_token_encoder #(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tte_in_if.sink      i_in,
    tte_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import tte_pkg::*;

    t_qwr   qwr;
    t_qstat qstat;
    t_entry head;
    logic   pop;

    tte_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_qstat     (qstat),
        .o_qwr       (qwr)
    );

    tte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    tte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // Never push into a full queue, never pop an empty one
    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, qwr.push, !qstat.full)
    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, pop, !qstat.empty)
    // An error result stands alone
    `ASSERT_IMPL(a_err_is_last, i_clk, i_rst_n, o_out.valid && o_out.status != ST_OK, o_out.last)
    // A popped entry leaves its final token on the output
    `ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, pop, o_out.valid && o_out.last)

endmodule

// File: src/tte_front.sv
module tte_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tte_in_if.sink              i_in,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  tte_pkg::t_qstat     i_qstat,
    output tte_pkg::t_qwr       o_qwr
);
    import tte_pkg::*;

    localparam int SUM_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [SUM_BITS-1:0] CNT_MAX =
        {{(SUM_BITS-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [15:0]           r_cap;
    logic [1:0]            r_level;
    logic [1:0]            n_level;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    logic                    accept;
    t_char_info              info;
    logic [MAX_TOK-1:0][4:0] list_tok;
    logic [2:0]              list_n;
    logic [1:0]              list_lvl;
    logic [SUM_BITS-1:0]     total;
    logic                    fit;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign info       = tte_classify(i_in.character);

    // Build the token list for a character or end command
    always_comb begin
        logic [2:0] lvl;
        logic [2:0] iv;
        logic [2:0] ups;
        lvl      = {1'b0, r_level};
        ups      = 3'd2 - lvl;
        list_tok = '0;
        list_n   = 3'd1;
        list_lvl = LVL_WORD;
        for (int i = 0; i < MAX_TOK; i++) begin
            iv = 3'(i);
            if (i_in.cmd == CMD_END) begin
                list_tok[i] = TOK_DOWN;
            end else begin
                case (info.cls)
                    CLS_DIGIT: begin
                        list_tok[i] = (iv <= lvl) ? TOK_DOWN :
                                      (iv == lvl + 3'd1) ? info.code : TOK_UP;
                    end
                    CLS_UPPER: list_tok[i] = (iv < lvl) ? TOK_DOWN : info.code;
                    CLS_LOWER: begin
                        if (iv == 3'd0 && r_level == LVL_WORD) begin
                            list_tok[i] = TOK_UP;
                        end else if (iv == 3'd0 && r_level == LVL_SPEC2) begin
                            list_tok[i] = TOK_DOWN;
                        end else begin
                            list_tok[i] = info.code;
                        end
                    end
                    CLS_PUNCT: list_tok[i] = (iv < ups) ? TOK_UP : info.code;
                    default:   list_tok[i] = 5'd0;
                endcase
            end
        end
        if (i_in.cmd == CMD_END) begin
            list_n = lvl + 3'd1;
        end else begin
            case (info.cls)
                CLS_DIGIT: list_n = lvl + 3'd3;
                CLS_UPPER: list_n = lvl + 3'd1;
                CLS_LOWER: begin
                    list_n   = (r_level == LVL_SPEC) ? 3'd1 : 3'd2;
                    list_lvl = LVL_SPEC;
                end
                CLS_PUNCT: begin
                    list_n   = ups + 3'd1;
                    list_lvl = LVL_SPEC2;
                end
                default:   list_n = 3'd1;
            endcase
        end
    end

    // Capacity check on the count after this item
    assign total = SUM_BITS'(r_count) + SUM_BITS'(list_n);
    assign fit   = (total <= SUM_BITS'(r_cap)) && (total <= CNT_MAX);

    // Decide the queued entry and the next state
    always_comb begin
        n_level            = r_level;
        n_count            = r_count;
        o_qwr.push         = 1'b0;
        o_qwr.entry.tok    = list_tok;
        o_qwr.entry.n      = list_n;
        o_qwr.entry.status = ST_OK;
        if (accept) begin
            case (i_in.cmd)
                CMD_BEGIN: begin
                    o_qwr.push = 1'b1;
                    if (r_cap == 16'd0) begin
                        o_qwr.entry.tok    = '0;
                        o_qwr.entry.n      = 3'd1;
                        o_qwr.entry.status = ST_OVF;
                    end else begin
                        o_qwr.entry.tok    = {(MAX_TOK){TOK_UP}};
                        o_qwr.entry.n      = 3'd1;
                        n_level            = LVL_WORD;
                        n_count            = COUNT_BITS'(1);
                    end
                end
                CMD_CHAR, CMD_END: begin
                    o_qwr.push = 1'b1;
                    if (i_in.cmd == CMD_CHAR && info.cls == CLS_BAD) begin
                        o_qwr.entry.tok    = '0;
                        o_qwr.entry.n      = 3'd1;
                        o_qwr.entry.status = ST_BAD;
                    end else if (!fit) begin
                        o_qwr.entry.tok    = '0;
                        o_qwr.entry.n      = 3'd1;
                        o_qwr.entry.status = ST_OVF;
                    end else begin
                        n_level = list_lvl;
                        n_count = total[COUNT_BITS-1:0];
                    end
                end
                default: o_qwr.push = 1'b0;
            endcase
        end
    end

    // Hold capacity, shift level and token count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 16'hFFFF;
            r_level <= LVL_WORD;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_level <= n_level;
            r_count <= n_count;
        end
    end

endmodule

// File: src/tte_queue.sv
module tte_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tte_pkg::t_qwr   i_qwr,
    input  logic            i_pop,
    output tte_pkg::t_entry o_head,
    output tte_pkg::t_qstat o_qstat
);
    import tte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign push          = i_qwr.push && !o_qstat.full;
    assign pop           = i_pop && !o_qstat.empty;
    assign o_qstat.full  = (r_cnt == CW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_head        = r_mem[r_rd];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_qwr.entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/tte_back.sv
module tte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tte_pkg::t_entry i_head,
    input  tte_pkg::t_qstat i_qstat,
    output logic            o_pop,
    tte_out_if.source       o_out
);
    import tte_pkg::*;

    logic       r_valid;
    logic [4:0] r_token;
    logic [1:0] r_status;
    logic       r_last;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       load;
    logic       at_end;

    assign load   = !i_qstat.empty && (!r_valid || o_out.ready);
    assign at_end = (r_idx == i_head.n - 3'd1);
    assign o_pop  = load && at_end;
    assign n_idx  = at_end ? 3'd0 : r_idx + 3'd1;

    assign o_out.valid  = r_valid;
    assign o_out.token  = r_token;
    assign o_out.status = r_status;
    assign o_out.last   = r_last;

    // Step through the head entry, one token per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token  <= i_head.tok[r_idx];
            r_status <= i_head.status;
            r_last   <= at_end;
        end
    end

endmodule
